[hw/rtl/ssmt_pkg.sv]
// Shared types and constants for the sparse-set membership table.
`default_nettype none

package ssmt_pkg;

   localparam int MAX_ENTITIES = 1024;
   localparam int IDX_W        = $clog2(MAX_ENTITIES);
   localparam int CNT_W        = IDX_W + 1;

   localparam int REQ_FIELD_W  = 16;
   localparam int REQ_TDATA_W  = 32;
   localparam int REQ_TUSER_W  = 2;
   localparam int RSP_TDATA_W  = 40;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_HAS    = 2'd2,
      OP_AT     = 2'd3
   } op_type;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_LOOK  = 8'b0000_0100,
      S_CHECK = 8'b0000_1000,
      S_ATRD  = 8'b0001_0000,
      S_MOVE  = 8'b0010_0000,
      S_UNMAP = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] slot;
   } map_entry_type;

   typedef struct packed {
      logic             ok;
      logic             already;
      logic             oor;
      logic [IDX_W-1:0] slot;
      logic [IDX_W-1:0] entity;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/ssmt_ram.sv]
// Single-port RAM with registered read data.
`default_nettype none

module ssmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[hw/rtl/sparse_set_membership_table_top.sv]
// Top level of the sparse-set membership table with swap-remove.
`default_nettype none

// One set of entity indices below 1024, kept as a sparse map (entity to dense
// slot) and a dense member list, both in single-port RAMs. Each request
// transaction carries one operation and yields exactly one response
// transaction. After reset the block sweeps the sparse map, one entry per
// cycle, holding req_tready low. It then takes one request at a time: an
// out-of-range request goes straight to the finishing state, an entity-at
// read reads the dense list only when the slot is below the member count, add
// and membership query read the sparse map and then the dense list, and a
// remove also moves the last member into the freed slot when needed and then
// clears the removed entity's map entry. Each RAM takes one read or write per
// cycle. A finished response sits in an output register until it is taken; a
// new request is accepted while it waits, but the next response holds the
// block in its finishing state, not ready, until that register is free.
module sparse_set_membership_table_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // entity [15:0], slot_query [31:16]
   input  wire logic [ssmt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // operation [1:0]
   input  wire logic [ssmt_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // ok [0], already_member [1], out_of_range [2], slot_out [12:3],
   // entity_out [22:13], member_count [33:23], zeros above
   output      logic [ssmt_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int IDX_W = ssmt_pkg::IDX_W;
   localparam int CNT_W = ssmt_pkg::CNT_W;
   localparam int MAP_W = $bits(ssmt_pkg::map_entry_type);

   ssmt_pkg::state_type     state_ff, state_in;
   ssmt_pkg::op_type        op_ff, op_in;
   logic [IDX_W-1:0]        ent_ff, ent_in;
   logic [IDX_W-1:0]        slot_ff, slot_in;
   logic                    cand_ff, cand_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        clr_ff, clr_in;
   ssmt_pkg::result_type    res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ssmt_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                    map_en, map_we;
   logic [IDX_W-1:0]        map_addr;
   logic [MAP_W-1:0]        map_wdata, map_rdata;
   logic                    dense_en, dense_we;
   logic [IDX_W-1:0]        dense_addr, dense_wdata, dense_rdata;

   ssmt_pkg::op_type        req_op;
   logic [ssmt_pkg::REQ_FIELD_W-1:0] req_ent, req_slot;
   ssmt_pkg::map_entry_type map_entry, map_new;
   logic                    found;
   logic [IDX_W-1:0]        last_idx;

   assign req_op   = ssmt_pkg::op_type'(req_tuser);
   assign req_ent  = req_tdata[ssmt_pkg::REQ_FIELD_W-1:0];
   assign req_slot = req_tdata[2*ssmt_pkg::REQ_FIELD_W-1:ssmt_pkg::REQ_FIELD_W];
   assign map_entry = ssmt_pkg::map_entry_type'(map_rdata);
   assign found    = cand_ff && (dense_rdata == ent_ff);
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));

   ssmt_ram #(
      .WIDTH (MAP_W),
      .DEPTH (ssmt_pkg::MAX_ENTITIES)
   ) u_sparse_map (
      .clock (clock),
      .en    (map_en),
      .we    (map_we),
      .addr  (map_addr),
      .wdata (map_wdata),
      .rdata (map_rdata)
   );

   ssmt_ram #(
      .WIDTH (IDX_W),
      .DEPTH (ssmt_pkg::MAX_ENTITIES)
   ) u_dense_list (
      .clock (clock),
      .en    (dense_en),
      .we    (dense_we),
      .addr  (dense_addr),
      .wdata (dense_wdata),
      .rdata (dense_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ent_in       = ent_ff;
      slot_in      = slot_ff;
      cand_in      = cand_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      map_en       = 1'b0;
      map_we       = 1'b0;
      map_addr     = ent_ff;
      map_new      = '0;
      dense_en     = 1'b0;
      dense_we     = 1'b0;
      dense_addr   = slot_ff;
      dense_wdata  = ent_ff;

      case (state_ff)
         ssmt_pkg::S_CLEAR: begin
            map_en   = 1'b1;
            map_we   = 1'b1;
            map_addr = clr_ff;
            clr_in   = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(ssmt_pkg::MAX_ENTITIES - 1)) begin
               state_in = ssmt_pkg::S_IDLE;
            end
         end
         ssmt_pkg::S_IDLE: begin
            if (req_tvalid) begin
               op_in  = req_op;
               ent_in = req_ent[IDX_W-1:0];
               res_in = '0;
               if (req_op == ssmt_pkg::OP_AT) begin
                  if (req_slot >= ssmt_pkg::REQ_FIELD_W'(ssmt_pkg::MAX_ENTITIES)) begin
                     res_in.oor = 1'b1;
                     state_in   = ssmt_pkg::S_DONE;
                  end else if (req_slot < ssmt_pkg::REQ_FIELD_W'(count_ff)) begin
                     dense_en   = 1'b1;
                     dense_addr = req_slot[IDX_W-1:0];
                     state_in   = ssmt_pkg::S_ATRD;
                  end else begin
                     state_in = ssmt_pkg::S_DONE;
                  end
               end else if (req_ent >= ssmt_pkg::REQ_FIELD_W'(ssmt_pkg::MAX_ENTITIES)) begin
                  res_in.oor = 1'b1;
                  state_in   = ssmt_pkg::S_DONE;
               end else begin
                  map_en   = 1'b1;
                  map_addr = req_ent[IDX_W-1:0];
                  state_in = ssmt_pkg::S_LOOK;
               end
            end
         end
         ssmt_pkg::S_LOOK: begin
            // A valid entry is only a candidate until the dense list confirms it.
            cand_in = map_entry.valid && (CNT_W'(map_entry.slot) < count_ff);
            slot_in = map_entry.slot;
            if (cand_in) begin
               dense_en   = 1'b1;
               dense_addr = map_entry.slot;
            end
            state_in = ssmt_pkg::S_CHECK;
         end
         ssmt_pkg::S_CHECK: begin
            state_in = ssmt_pkg::S_DONE;
            case (op_ff)
               ssmt_pkg::OP_ADD: begin
                  if (found) begin
                     res_in.ok      = 1'b1;
                     res_in.already = 1'b1;
                     res_in.slot    = slot_ff;
                  end else if (count_ff < CNT_W'(ssmt_pkg::MAX_ENTITIES)) begin
                     dense_en      = 1'b1;
                     dense_we      = 1'b1;
                     dense_addr    = count_ff[IDX_W-1:0];
                     dense_wdata   = ent_ff;
                     map_en        = 1'b1;
                     map_we        = 1'b1;
                     map_addr      = ent_ff;
                     map_new.valid = 1'b1;
                     map_new.slot  = count_ff[IDX_W-1:0];
                     count_in      = count_ff + CNT_W'(1);
                     res_in.ok     = 1'b1;
                     res_in.slot   = count_ff[IDX_W-1:0];
                  end
               end
               ssmt_pkg::OP_REMOVE: begin
                  if (found) begin
                     res_in.ok = 1'b1;
                     if (slot_ff != last_idx) begin
                        dense_en   = 1'b1;
                        dense_addr = last_idx;
                        state_in   = ssmt_pkg::S_MOVE;
                     end else begin
                        state_in = ssmt_pkg::S_UNMAP;
                     end
                  end
               end
               ssmt_pkg::OP_HAS: begin
                  if (found) begin
                     res_in.ok   = 1'b1;
                     res_in.slot = slot_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         ssmt_pkg::S_ATRD: begin
            res_in.ok     = 1'b1;
            res_in.entity = dense_rdata;
            state_in      = ssmt_pkg::S_DONE;
         end
         ssmt_pkg::S_MOVE: begin
            // The last member takes over the freed slot.
            dense_en      = 1'b1;
            dense_we      = 1'b1;
            dense_addr    = slot_ff;
            dense_wdata   = dense_rdata;
            map_en        = 1'b1;
            map_we        = 1'b1;
            map_addr      = dense_rdata;
            map_new.valid = 1'b1;
            map_new.slot  = slot_ff;
            state_in      = ssmt_pkg::S_UNMAP;
         end
         ssmt_pkg::S_UNMAP: begin
            map_en   = 1'b1;
            map_we   = 1'b1;
            map_addr = ent_ff;
            count_in = count_ff - CNT_W'(1);
            state_in = ssmt_pkg::S_DONE;
         end
         ssmt_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = ssmt_pkg::RSP_TDATA_W'({count_ff, res_ff.entity, res_ff.slot,
                                                      res_ff.oor, res_ff.already, res_ff.ok});
               state_in     = ssmt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ssmt_pkg::S_IDLE;
         end
      endcase

      map_wdata = map_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssmt_pkg::S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      ent_ff      <= ent_in;
      slot_ff     <= slot_in;
      cand_ff     <= cand_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ssmt_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The member count never exceeds the capacity.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ssmt_pkg::MAX_ENTITIES))
      else $error("member count beyond capacity");

   // The count moves by at most one per step.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ((count_ff == $past(count_ff) + CNT_W'(1)) ||
          (count_ff == $past(count_ff) - CNT_W'(1))))
      else $error("member count jumped");

   // A new response is only loaded from the finishing state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ssmt_pkg::S_DONE))
      else $error("response loaded outside the finishing state");

   // A rejected request never reports success.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[2]) |-> !rsp_data_ff[0])
      else $error("out-of-range response flagged ok");

endmodule

`default_nettype wire

[tb/sparse_set_membership_table_top_test.sv]
// Self-checking testbench for the sparse-set membership table.
`timescale 1ns / 100ps

module sparse_set_membership_table_top_test;

   localparam int MAX_ENTITIES = ssmt_pkg::MAX_ENTITIES;
   localparam int IDX_W        = ssmt_pkg::IDX_W;
   localparam int CNT_W        = ssmt_pkg::CNT_W;
   localparam int REQ_TDATA_W  = ssmt_pkg::REQ_TDATA_W;
   localparam int REQ_TUSER_W  = ssmt_pkg::REQ_TUSER_W;
   localparam int RSP_TDATA_W  = ssmt_pkg::RSP_TDATA_W;

   localparam int LIMIT_CYCLES = 400000;
   localparam int POOL_SIZE    = 32;
   localparam int TAIL_ITEMS   = 150;

   // Response fields from the top bit of member_count down to ok, so the
   // packed struct lines up with rsp_tdata[33:0].
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [IDX_W-1:0] entity;
      logic [IDX_W-1:0] slot;
      logic             oor;
      logic             already;
      logic             ok;
   } answer_type;

   typedef struct {
      ssmt_pkg::op_type op;
      logic [15:0]      entity;
      logic [15:0]      slot_query;
      bit               typed;
      answer_type       answer;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Shadow copy of the set: membership, dense slot per entity, dense list.
   bit      in_set [MAX_ENTITIES];
   int      slot_of [MAX_ENTITIES];
   int      member_list [MAX_ENTITIES];
   int      members;

   answer_type   pending_answers [$];
   stim_row_type stim_rows [$];
   int           entity_pool [POOL_SIZE];
   int           fill_order [MAX_ENTITIES];
   bit           idle_enable;
   int           mismatches;
   int           answers_seen;
   int           op_tally [4];
   int           oor_tally;
   int           peak_members;
   int           stall_left;

   sparse_set_membership_table_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit locate_member(int ent, output int slot);
      slot = 0;
      if (!in_set[ent] || slot_of[ent] >= members || member_list[slot_of[ent]] != ent)
         return 1'b0;
      slot = slot_of[ent];
      return 1'b1;
   endfunction

   // Applies one operation to the shadow set and returns the response it owes.
   function automatic answer_type predict_answer(ssmt_pkg::op_type op, logic [15:0] ent,
                                                 logic [15:0] q);
      answer_type a;
      int         s;
      int         last;
      int         moved;
      a = '0;
      if (op == ssmt_pkg::OP_AT) begin
         if (q >= MAX_ENTITIES) begin
            a.oor = 1'b1;
         end else if (q < members) begin
            a.ok     = 1'b1;
            a.entity = IDX_W'(member_list[q]);
         end
      end else if (ent >= MAX_ENTITIES) begin
         a.oor = 1'b1;
      end else begin
         case (op)
            ssmt_pkg::OP_ADD: begin
               if (locate_member(ent, s)) begin
                  a.ok      = 1'b1;
                  a.already = 1'b1;
                  a.slot    = IDX_W'(s);
               end else if (members < MAX_ENTITIES) begin
                  member_list[members] = ent;
                  in_set[ent]          = 1'b1;
                  slot_of[ent]         = members;
                  a.ok                 = 1'b1;
                  a.slot               = IDX_W'(members);
                  members++;
               end
            end
            ssmt_pkg::OP_REMOVE: begin
               if (locate_member(ent, s)) begin
                  last = members - 1;
                  // Swap-remove: the last member fills the hole.
                  if (s != last) begin
                     moved              = member_list[last];
                     member_list[s]     = moved;
                     slot_of[moved]     = s;
                  end
                  members      = last;
                  in_set[ent]  = 1'b0;
                  slot_of[ent] = 0;
                  a.ok         = 1'b1;
               end
            end
            default: begin
               if (locate_member(ent, s)) begin
                  a.ok   = 1'b1;
                  a.slot = IDX_W'(s);
               end
            end
         endcase
      end
      a.count = CNT_W'(members);
      return a;
   endfunction

   function automatic answer_type make_answer(bit ok, bit already, bit oor, int slot,
                                              int ent, int cnt);
      answer_type a;
      a.ok      = ok;
      a.already = already;
      a.oor     = oor;
      a.slot    = IDX_W'(slot);
      a.entity  = IDX_W'(ent);
      a.count   = CNT_W'(cnt);
      return a;
   endfunction

   function automatic void add_row(ssmt_pkg::op_type op, int ent, int q, bit typed,
                                   answer_type a);
      stim_row_type r;
      r.op         = op;
      r.entity     = 16'(ent);
      r.slot_query = 16'(q);
      r.typed      = typed;
      r.answer     = a;
      stim_rows.push_back(r);
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Drives one request transaction, with an occasional gap before it, and
   // records the response it should produce once the block takes it.
   task automatic send_request(ssmt_pkg::op_type op, logic [15:0] ent, logic [15:0] q,
                               bit typed, answer_type typed_answer);
      answer_type a;
      @(negedge clock);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {q, ent};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      a = predict_answer(op, ent, q);
      if (typed)
         a = typed_answer;
      pending_answers.push_back(a);
      op_tally[op]++;
      if (a.oor)
         oor_tally++;
      if (members > peak_members)
         peak_members = members;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
   endtask

   task automatic issue_query();
      if ($urandom_range(0, 1) != 0)
         send_request(ssmt_pkg::OP_HAS, 16'($urandom_range(0, MAX_ENTITIES - 1)),
                      16'($urandom), 1'b0, '0);
      else
         send_request(ssmt_pkg::OP_AT, 16'($urandom),
                      16'($urandom_range(0, MAX_ENTITIES - 1)), 1'b0, '0);
   endtask

   // Mostly well-formed operations, on a small pool of entities when pooled is set, so
   // that adds, removes and queries keep meeting each other; a few are out-of-range noise.
   task automatic issue_random(int add_pct, bit pooled);
      int               r;
      int               hi;
      ssmt_pkg::op_type op;
      logic [15:0]      ent;
      logic [15:0]      q;
      q = 16'($urandom);
      r = $urandom_range(0, 99);
      if (r < 5) begin
         op = ssmt_pkg::op_type'($urandom_range(0, 3));
         if ($urandom_range(0, 1) != 0)
            ent = 16'($urandom_range(MAX_ENTITIES, 65535));
         else
            ent = 16'($urandom);
         if (op == ssmt_pkg::OP_AT)
            q = 16'($urandom_range(MAX_ENTITIES, 65535));
      end else begin
         if ($urandom_range(0, 99) < add_pct)
            op = ssmt_pkg::OP_ADD;
         else
            op = ssmt_pkg::op_type'($urandom_range(1, 3));
         if (pooled && $urandom_range(0, 4) != 0)
            ent = 16'(entity_pool[$urandom_range(0, POOL_SIZE - 1)]);
         else
            ent = 16'($urandom_range(0, MAX_ENTITIES - 1));
         if (op == ssmt_pkg::OP_AT) begin
            hi  = (members + 2 > MAX_ENTITIES - 1) ? MAX_ENTITIES - 1 : members + 2;
            ent = 16'($urandom);
            q   = 16'($urandom_range(0, hi));
         end
      end
      send_request(op, ent, q, 1'b0, '0);
   endtask

   // The receiver stalls in random bursts while idle_enable is set.
   initial begin
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (idle_enable && stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(1, 11) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watch_responses
      answer_type want;
      answer_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         answers_seen++;
         got = answer_type'(rsp_tdata[33:0]);
         if (pending_answers.size() == 0) begin
            $display("%0t: response with none expected, actual %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_answers.pop_front();
            check_field("ok", want.ok, got.ok);
            check_field("already_member", want.already, got.already);
            check_field("out_of_range", want.oor, got.oor);
            check_field("slot_out", want.slot, got.slot);
            check_field("entity_out", want.entity, got.entity);
            check_field("member_count", want.count, got.count);
            check_field("padding", 0, rsp_tdata[RSP_TDATA_W-1:34]);
         end
      end
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("Timed out with %0d responses outstanding.", pending_answers.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int         j;
      int         tmp;
      answer_type none;
      none         = '0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = ssmt_pkg::OP_ADD;
      idle_enable  = 1'b1;
      mismatches   = 0;
      answers_seen = 0;
      oor_tally    = 0;
      peak_members = 0;
      members      = 0;
      foreach (op_tally[k]) op_tally[k] = 0;
      foreach (in_set[k]) begin
         in_set[k]      = 1'b0;
         slot_of[k]     = 0;
         member_list[k] = 0;
         fill_order[k]  = k;
      end
      entity_pool[0] = 0;
      entity_pool[1] = MAX_ENTITIES - 1;
      for (int k = 2; k < POOL_SIZE; k++)
         entity_pool[k] = $urandom_range(0, MAX_ENTITIES - 1);

      // Directed rows: empty table, both ends of the index range, the
      // out-of-range cases, a repeated add, and swap-remove with and without
      // a moved member.
      add_row(ssmt_pkg::OP_HAS, 5, 0, 1'b1, make_answer(0, 0, 0, 0, 0, 0));
      add_row(ssmt_pkg::OP_AT, 0, 0, 1'b1, make_answer(0, 0, 0, 0, 0, 0));
      add_row(ssmt_pkg::OP_REMOVE, 5, 0, 1'b1, make_answer(0, 0, 0, 0, 0, 0));
      add_row(ssmt_pkg::OP_ADD, 0, 0, 1'b1, make_answer(1, 0, 0, 0, 0, 1));
      add_row(ssmt_pkg::OP_ADD, MAX_ENTITIES - 1, 16'hFFFF, 1'b1,
              make_answer(1, 0, 0, 1, 0, 2));
      add_row(ssmt_pkg::OP_ADD, MAX_ENTITIES, 0, 1'b1, make_answer(0, 0, 1, 0, 0, 2));
      add_row(ssmt_pkg::OP_ADD, 16'hFFFF, 0, 1'b1, make_answer(0, 0, 1, 0, 0, 2));
      add_row(ssmt_pkg::OP_REMOVE, 16'hFFFF, 0, 1'b1, make_answer(0, 0, 1, 0, 0, 2));
      add_row(ssmt_pkg::OP_HAS, 16'hFFFF, 0, 1'b1, make_answer(0, 0, 1, 0, 0, 2));
      add_row(ssmt_pkg::OP_AT, 0, MAX_ENTITIES, 1'b1, make_answer(0, 0, 1, 0, 0, 2));
      add_row(ssmt_pkg::OP_AT, 16'hFFFF, 16'hFFFF, 1'b1, make_answer(0, 0, 1, 0, 0, 2));
      add_row(ssmt_pkg::OP_ADD, 0, 0, 1'b1, make_answer(1, 1, 0, 0, 0, 2));
      add_row(ssmt_pkg::OP_ADD, 16'h0155, 0, 1'b0, none);
      add_row(ssmt_pkg::OP_ADD, 16'h02AA, 0, 1'b0, none);
      add_row(ssmt_pkg::OP_HAS, MAX_ENTITIES - 1, 0, 1'b0, none);
      add_row(ssmt_pkg::OP_AT, 0, 1, 1'b0, none);
      add_row(ssmt_pkg::OP_AT, 0, MAX_ENTITIES - 1, 1'b0, none);
      add_row(ssmt_pkg::OP_REMOVE, 0, 0, 1'b0, none);
      add_row(ssmt_pkg::OP_HAS, 0, 0, 1'b0, none);
      add_row(ssmt_pkg::OP_AT, 0, 0, 1'b0, none);
      add_row(ssmt_pkg::OP_REMOVE, 16'h02AA, 0, 1'b0, none);
      add_row(ssmt_pkg::OP_HAS, 16'h02AA, 0, 1'b0, none);
      add_row(ssmt_pkg::OP_REMOVE, MAX_ENTITIES - 1, 0, 1'b0, none);
      add_row(ssmt_pkg::OP_REMOVE, 16'h0155, 0, 1'b0, none);
      add_row(ssmt_pkg::OP_AT, 0, 0, 1'b0, none);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The first request waits out the sparse-map clearing pass.
      foreach (stim_rows[k])
         send_request(stim_rows[k].op, stim_rows[k].entity, stim_rows[k].slot_query,
                      stim_rows[k].typed, stim_rows[k].answer);
      wait_drained();

      repeat (300) issue_random(40, 1'b1);

      // Fill the table completely in a shuffled order, with queries mixed in.
      for (int k = MAX_ENTITIES - 1; k > 0; k--) begin
         j             = $urandom_range(0, k);
         tmp           = fill_order[k];
         fill_order[k] = fill_order[j];
         fill_order[j] = tmp;
      end
      foreach (fill_order[k]) begin
         if ($urandom_range(0, 9) == 0)
            issue_query();
         send_request(ssmt_pkg::OP_ADD, 16'(fill_order[k]), 16'($urandom), 1'b0, '0);
      end
      wait_drained();

      send_request(ssmt_pkg::OP_AT, 16'($urandom), 16'(MAX_ENTITIES - 1), 1'b0, '0);
      send_request(ssmt_pkg::OP_ADD, 16'($urandom_range(0, MAX_ENTITIES - 1)), 0,
                   1'b0, '0);
      repeat (70) issue_random(30, 1'b0);
      idle_enable = 1'b0;
      repeat (TAIL_ITEMS) issue_random(30, 1'b1);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Ran %0d adds, %0d removes, %0d queries and %0d entity-at reads; %0d out of range.",
               op_tally[ssmt_pkg::OP_ADD], op_tally[ssmt_pkg::OP_REMOVE],
               op_tally[ssmt_pkg::OP_HAS], op_tally[ssmt_pkg::OP_AT], oor_tally);
      $display("Peak member count %0d of %0d, %0d responses checked, %0d mismatches.",
               peak_members, MAX_ENTITIES, answers_seen, mismatches);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/ssmt_pkg.sv
hw/rtl/ssmt_ram.sv
hw/rtl/sparse_set_membership_table_top.sv
tb/sparse_set_membership_table_top_test.sv
